// ----- rtl/core/xed_pkg.sv -----
// Package for the XML entity decoder core: payload structs, controller states,
// command and status bundles, and character codes. No dependencies.
package xed_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} xed_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} xed_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_DRAIN_MID,
		ST_DRAIN_FIN,
		ST_AMP
	} xed_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load_emit;
		logic append;
		logic load_amp;
		logic clear_cnt;
		logic push_emit;
		logic push_drain;
		logic drain_last;
	} xed_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_amp;
		logic is_semi;
		logic cnt_zero;
		logic full_next;
		logic hit;
		logic in_last;
		logic last_q;
		logic slot_free;
		logic drain_final;
	} xed_status_t;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_G    = 8'h67;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_O    = 8'h6F;
	localparam logic [7:0] CH_S    = 8'h73;
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_U    = 8'h75;

endpackage

// ----- rtl/core/xed_datapath.sv -----
// Datapath of the XML entity decoder: hold buffer, fill count, drain pointer,
// entity match logic and the output register. Depends on xed_pkg.
module xed_datapath #(
	parameter int HOLD_DEPTH = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  xed_pkg::xed_in_t  in_data,
	output xed_pkg::xed_out_t out_data,
	output logic            out_valid,
	input  logic            out_stall,
	input  xed_pkg::xed_cmd_t   cmd,
	output xed_pkg::xed_status_t st
);
	import xed_pkg::*;

	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam int IW = $clog2(HOLD_DEPTH);

	logic [7:0]    buf_q [HOLD_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] rd_q;
	logic          last_q;
	xed_out_t      emit_q;
	xed_out_t      out_q;
	logic          out_valid_q;

	logic       is_semi;
	logic       hit;
	logic [7:0] hit_char;
	logic       drain_final;
	logic       slot_free;
	logic       push;

	// A ';' completes a known entity when the held bytes spell its body.
	always_comb begin
		is_semi  = (in_data.in_byte == CH_SEMI);
		hit      = 1'b0;
		hit_char = CH_AMP;
		if (is_semi && buf_q[0] == CH_AMP) begin
			if (cnt_q == CW'(3) && buf_q[1] == CH_L && buf_q[2] == CH_T) begin
				hit      = 1'b1;
				hit_char = CH_LT;
			end else if (cnt_q == CW'(3) && buf_q[1] == CH_G && buf_q[2] == CH_T) begin
				hit      = 1'b1;
				hit_char = CH_GT;
			end else if (cnt_q == CW'(4) && buf_q[1] == CH_A && buf_q[2] == CH_M
					&& buf_q[3] == CH_P) begin
				hit      = 1'b1;
				hit_char = CH_AMP;
			end else if (cnt_q == CW'(5) && buf_q[1] == CH_A && buf_q[2] == CH_P
					&& buf_q[3] == CH_O && buf_q[4] == CH_S) begin
				hit      = 1'b1;
				hit_char = CH_APOS;
			end else if (cnt_q == CW'(5) && buf_q[1] == CH_Q && buf_q[2] == CH_U
					&& buf_q[3] == CH_O && buf_q[4] == CH_T) begin
				hit      = 1'b1;
				hit_char = CH_QUOT;
			end
		end
	end

	assign drain_final = ((CW'(rd_q) + CW'(1)) == cnt_q);
	assign slot_free   = !out_valid_q || !out_stall;
	assign push        = cmd.push_emit || cmd.push_drain;

	assign st.is_amp      = (in_data.in_byte == CH_AMP);
	assign st.is_semi     = is_semi;
	assign st.cnt_zero    = (cnt_q == '0);
	assign st.full_next   = (cnt_q == CW'(HOLD_DEPTH - 1));
	assign st.hit         = hit;
	assign st.in_last     = in_data.in_last;
	assign st.last_q      = last_q;
	assign st.slot_free   = slot_free;
	assign st.drain_final = drain_final;

	// Hold buffer contents need no reset; only entries below the count are read.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			buf_q[cnt_q[IW-1:0]] <= in_data.in_byte;
		end
		if (cmd.load_amp) begin
			buf_q[0] <= CH_AMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else begin
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.push_drain && drain_final) begin
				cnt_q <= '0;
			end else if (cmd.load_amp) begin
				cnt_q <= CW'(1);
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.push_drain) begin
				rd_q <= drain_final ? '0 : rd_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			last_q <= in_data.in_last;
		end
		if (cmd.load_emit) begin
			emit_q.out_byte <= hit ? hit_char : in_data.in_byte;
			emit_q.out_last <= in_data.in_last;
		end
		if (cmd.push_emit) begin
			out_q <= emit_q;
		end else if (cmd.push_drain) begin
			out_q.out_byte <= buf_q[rd_q];
			out_q.out_last <= cmd.drain_last && drain_final && last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HOLD_DEPTH))
		else $error("hold count exceeds buffer depth");

	a_head_amp: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (buf_q[0] == CH_AMP))
		else $error("held sequence does not start with an ampersand");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_drain && drain_final) |=> (cnt_q == '0 && rd_q == '0))
		else $error("hold buffer not empty after final drain transfer");

endmodule

// ----- rtl/core/xed_ctrl.sv -----
// Controller state machine of the XML entity decoder. Issues commands to
// xed_datapath from its status. Depends on xed_pkg.
module xed_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  xed_pkg::xed_status_t st,
	output xed_pkg::xed_cmd_t    cmd
);
	import xed_pkg::*;

	xed_state_t state_q;
	xed_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (st.is_amp) begin
						if (st.cnt_zero) begin
							cmd.load_amp = 1'b1;
							state_d      = st.in_last ? ST_DRAIN_FIN : ST_IDLE;
						end else begin
							state_d = ST_DRAIN_MID;
						end
					end else if (st.cnt_zero) begin
						cmd.load_emit = 1'b1;
						state_d       = ST_EMIT;
					end else begin
						cmd.append = 1'b1;
						if (st.hit) begin
							cmd.load_emit = 1'b1;
							cmd.clear_cnt = 1'b1;
							state_d       = ST_EMIT;
						end else if (st.is_semi || st.full_next || st.in_last) begin
							// An unknown entity, a full hold or the end of the
							// string releases the held bytes unchanged.
							state_d = ST_DRAIN_FIN;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_EMIT: begin
				if (st.slot_free) begin
					cmd.push_emit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_DRAIN_MID: begin
				if (st.slot_free) begin
					cmd.push_drain = 1'b1;
					if (st.drain_final) begin
						state_d = ST_AMP;
					end
				end
			end
			ST_DRAIN_FIN: begin
				if (st.slot_free) begin
					cmd.push_drain = 1'b1;
					cmd.drain_last = 1'b1;
					if (st.drain_final) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_AMP: begin
				cmd.load_amp = 1'b1;
				state_d      = st.last_q ? ST_DRAIN_FIN : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN_MID || state_q == ST_DRAIN_FIN) |-> !st.cnt_zero)
		else $error("drain state entered with an empty hold buffer");

	a_amp_follows_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AMP) |-> ($past(state_q) == ST_DRAIN_MID))
		else $error("ampersand reload without a preceding flush");

	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && st.slot_free) |=> (state_q == ST_IDLE))
		else $error("single byte emit did not return to idle");

endmodule

// ----- rtl/core/xml_entity_decoder_core.sv -----
// Top level of the XML entity decoder: joins the controller and datapath.
// Depends on xed_pkg, xed_ctrl and xed_datapath.
//
// Usage: encoded text enters one byte per transfer on the input channel
// (in_valid, in_stall, in_data); decoded text leaves one byte per transfer on
// the output channel (out_valid, out_stall, out_data). The five predefined
// entities &lt; &gt; &amp; &apos; &quot; become a single character; any other
// '&' sequence comes out unchanged. in_last on an input byte flushes held
// bytes, and out_last marks the final decoded byte of that string.
// The controller handles one input byte at a time and takes no new byte until
// it has emitted or drained what that byte releases; a flush caused by a new
// '&' also reloads it into the hold buffer. The single output register moves
// at most one byte per cycle. The input is stalled whenever the controller is
// not idle. When the receiver stalls, the output register holds its byte and
// the controller waits.
// Reset empties the hold buffer and the output register; the held byte
// storage itself is not cleared and is written before it is read.
module xml_entity_decoder_core #(
	parameter int HOLD_DEPTH = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  xed_pkg::xed_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output xed_pkg::xed_out_t out_data
);
	import xed_pkg::*;

	xed_cmd_t    cmd;
	xed_status_t st;

	// Sequencing: accept a byte, then hold it, emit a single byte or drain the hold buffer.
	xed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Storage, entity match and the output register.
	xed_datapath #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
